[hw/rtl/strm_pkg.sv]
// Shared types and constants for the sparse-table range-minimum engine.
package strm_pkg;

  // Fixed field widths of the stream words and the length register
  localparam int FIELD_IDX_W = 10;
  localparam int SPAN_LOG_W  = 4;
  localparam int LEN_W       = 11;
  localparam int LEN_RESET   = 1024;

  // Configuration port
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  // Register index (byte address bit 2)
  localparam logic REG_LENGTH = 1'b0;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Input word selector
  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_BUILD = 2'd1,
    FN_QUERY = 2'd2
  } func_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_COPY,
    ST_LEVEL,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/sparse_table_range_min_top.sv]
// Sparse-table range-minimum engine: element store, level table and build sequencer.
//
// Usage:
//   in_*  : one word per command. in_tuser selects write element, build table or
//           range query; in_tdata carries index, value, range_lo and range_hi.
//   out_* : exactly one result word per command: min_value in out_tdata and the
//           status flag (1 = bad range, bad index or bad selector) in out_tuser.
//   cfg_* : APB register port; register 0 (address 0) is the active length.
// A write, a rejected query or an unknown selector answers in the cycle after
// acceptance; a good query first reads the table memory on both read ports into
// registers, then registers the compare result in the output register.
// A build copies n elements into level 0 and then sweeps each level, one table
// entry per cycle, with one turnaround step per level and one step to finish;
// the single write port of the table memory sets that rate.
// One command is in flight at a time; the next is taken as soon as the output
// register is empty or is being drained in the same cycle.
// Reset: the element store is swept to zero, one entry per cycle, across all
// MAX_ENTRIES entries; in_tready stays low meanwhile (register writes still work).
// A stalled receiver holds the result in the output register; in_tready drops
// until that word is taken.
module sparse_table_range_min_top
  import strm_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int VALUE_WIDTH = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tdata: index, value, range_lo, range_hi (from bit 0 up), zero padded
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [((3*FIELD_IDX_W+VALUE_WIDTH+7)/8)*8-1:0] in_tdata,
  // in_tuser: func
  input  logic [1:0]                 in_tuser,
  // out_tdata: min_value, zero padded
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [((VALUE_WIDTH+7)/8)*8-1:0] out_tdata,
  // out_tuser: status
  output logic                       out_tuser,
  // register port
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [CFG_AW-1:0]          cfg_paddr,
  input  logic [CFG_DW-1:0]          cfg_pwdata,
  output logic [CFG_DW-1:0]          cfg_prdata,
  output logic                       cfg_pready
);

  localparam int IDX_W     = $clog2(MAX_ENTRIES);
  localparam int LEVELS    = IDX_W + 1;
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int TBL_DEPTH = LEVELS * MAX_ENTRIES;
  localparam int TA_W      = $clog2(TBL_DEPTH);
  localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int NW        = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int EXT_W     = (IDX_W > FIELD_IDX_W) ? IDX_W : FIELD_IDX_W;
  localparam int LX_W      = (LVL_W > SPAN_LOG_W) ? LVL_W : SPAN_LOG_W;
  localparam int OUT_DW    = ((VALUE_WIDTH + 7) / 8) * 8;

  typedef logic [VALUE_WIDTH-1:0] val_t;

  // ---------------------------------------------------------------------------
  // Helpers
  function automatic logic [TA_W-1:0] tbl_addr(input logic [LVL_W-1:0] lv,
                                               input logic [IDX_W-1:0] ix);
    return TA_W'(lv) * TA_W'(MAX_ENTRIES) + TA_W'(ix);
  endfunction

  function automatic val_t vmin(input val_t a, input val_t b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  // ---------------------------------------------------------------------------
  // Input word fields
  logic [FIELD_IDX_W-1:0] f_index, f_lo, f_hi;
  val_t                   f_value;
  func_t                  f_func;

  assign f_index = in_tdata[FIELD_IDX_W-1:0];
  assign f_value = in_tdata[FIELD_IDX_W +: VALUE_WIDTH];
  assign f_lo    = in_tdata[FIELD_IDX_W+VALUE_WIDTH +: FIELD_IDX_W];
  assign f_hi    = in_tdata[2*FIELD_IDX_W+VALUE_WIDTH +: FIELD_IDX_W];
  assign f_func  = func_t'(in_tuser);

  // ---------------------------------------------------------------------------
  // Registers
  state_t               state_r, state_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;
  logic [LVL_W-1:0]     lvl_r, lvl_nxt;
  logic [LEN_W-1:0]     length_r;
  logic                 wpend_r, wpend_nxt;
  logic                 wlevel_r, wlevel_nxt;
  logic [TA_W-1:0]      waddr_r, waddr_nxt;
  logic                 out_vld_r;
  val_t                 out_min_r;
  logic                 out_st_r;

  // Memories and their read registers
  val_t                 elem_mem [MAX_ENTRIES];
  val_t                 tbl_mem  [TBL_DEPTH];
  val_t                 elem_rd_r, tbl_rd_a_r, tbl_rd_b_r;

  logic                 elem_we;
  logic [IDX_W-1:0]     elem_waddr;
  val_t                 elem_wdata;
  logic [TA_W-1:0]      tbl_ra, tbl_rb;
  val_t                 tbl_wdata;

  logic                 in_acc;
  logic                 out_load;
  val_t                 out_min_nxt;
  logic                 out_st_nxt;

  // ---------------------------------------------------------------------------
  // Active length, clipped to capacity
  logic [NW-1:0] len_ext, n_act;
  logic [NW:0]   n_w;
  assign len_ext = NW'(length_r);
  assign n_act   = (len_ext > NW'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : len_ext;
  assign n_w     = (NW+1)'(n_act);

  // ---------------------------------------------------------------------------
  // Query decode: range check, level and the two window starts
  logic [FIELD_IDX_W-1:0] q_span;
  logic [SPAN_LOG_W-1:0]  q_lv;
  logic [LX_W-1:0]        q_lv_ext;
  logic [EXT_W-1:0]       q_lo_ext, q_rb_ext;
  logic                   q_bad;
  logic                   wr_ok;
  logic [EXT_W-1:0]       w_idx_ext;

  assign q_bad  = (f_lo > f_hi) || (NW'(f_hi) >= n_act);
  assign q_span = f_hi - f_lo;

  always_comb begin
    q_lv = '0;
    for (int b = 0; b < FIELD_IDX_W; b++) begin
      if (q_span[b]) q_lv = SPAN_LOG_W'(b);
    end
  end

  assign q_lv_ext  = LX_W'(q_lv);
  assign q_lo_ext  = EXT_W'(f_lo);
  assign q_rb_ext  = EXT_W'(f_hi) - (EXT_W'(1) << q_lv) + EXT_W'(1);
  assign w_idx_ext = EXT_W'(f_index);
  assign wr_ok     = NW'(f_index) < n_act;

  // ---------------------------------------------------------------------------
  // Build sweep terms
  logic [NW:0] k_w, cnt_w, cnt_k_w;
  logic        copy_issue, lvl_issue;

  assign k_w        = (NW+1)'(1) << lvl_r;
  assign cnt_w      = (NW+1)'(cnt_r);
  assign cnt_k_w    = cnt_w + k_w;
  assign copy_issue = cnt_w < n_w;
  assign lvl_issue  = cnt_k_w < n_w;

  assign in_tready  = (state_r == ST_IDLE) && (!out_vld_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_r == NW'(MAX_ENTRIES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (f_func == FN_BUILD) state_nxt = ST_COPY;
          else if (f_func == FN_QUERY && !q_bad) state_nxt = ST_QUERY;
        end
      end
      ST_QUERY: state_nxt = ST_IDLE;
      ST_COPY: begin
        if (!copy_issue) state_nxt = (k_w < n_w) ? ST_LEVEL : ST_DONE;
      end
      ST_LEVEL: begin
        if (!lvl_issue) state_nxt = ((k_w << 1) < n_w) ? ST_LEVEL : ST_DONE;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath control: counters, memory ports, result load
  always_comb begin
    cnt_nxt     = cnt_r;
    lvl_nxt     = lvl_r;
    wpend_nxt   = 1'b0;
    wlevel_nxt  = wlevel_r;
    waddr_nxt   = waddr_r;
    elem_we     = 1'b0;
    elem_waddr  = cnt_r[IDX_W-1:0];
    elem_wdata  = '0;
    tbl_ra      = tbl_addr(lvl_r, cnt_r[IDX_W-1:0]);
    tbl_rb      = tbl_addr(lvl_r, cnt_k_w[IDX_W-1:0]);
    out_load    = 1'b0;
    out_min_nxt = '0;
    out_st_nxt  = STATUS_OK;
    case (state_r)
      // zero the element store after reset
      ST_CLEAR: begin
        elem_we = 1'b1;
        cnt_nxt = cnt_r + NW'(1);
      end
      ST_IDLE: begin
        tbl_ra = tbl_addr(q_lv_ext[LVL_W-1:0], q_lo_ext[IDX_W-1:0]);
        tbl_rb = tbl_addr(q_lv_ext[LVL_W-1:0], q_rb_ext[IDX_W-1:0]);
        if (in_acc) begin
          case (f_func)
            FN_WRITE: begin
              elem_we    = wr_ok;
              elem_waddr = w_idx_ext[IDX_W-1:0];
              elem_wdata = f_value;
              out_load   = 1'b1;
              out_st_nxt = wr_ok ? STATUS_OK : STATUS_ERR;
            end
            FN_BUILD: begin
              cnt_nxt = '0;
              lvl_nxt = '0;
            end
            FN_QUERY: begin
              out_load   = q_bad;
              out_st_nxt = STATUS_ERR;
            end
            default: begin
              out_load   = 1'b1;
              out_st_nxt = STATUS_ERR;
            end
          endcase
        end
      end
      ST_QUERY: begin
        out_load    = 1'b1;
        out_min_nxt = vmin(tbl_rd_a_r, tbl_rd_b_r);
      end
      // level 0 gets a copy of the element store
      ST_COPY: begin
        wlevel_nxt = 1'b0;
        waddr_nxt  = tbl_addr('0, cnt_r[IDX_W-1:0]);
        if (copy_issue) begin
          wpend_nxt = 1'b1;
          cnt_nxt   = cnt_r + NW'(1);
        end else begin
          cnt_nxt = '0;
        end
      end
      // level l+1 entry i = min of level l entries i and i + 2^l
      ST_LEVEL: begin
        wlevel_nxt = 1'b1;
        waddr_nxt  = tbl_addr(lvl_r + LVL_W'(1), cnt_r[IDX_W-1:0]);
        if (lvl_issue) begin
          wpend_nxt = 1'b1;
          cnt_nxt   = cnt_r + NW'(1);
        end else begin
          cnt_nxt = '0;
          lvl_nxt = lvl_r + LVL_W'(1);
        end
      end
      ST_DONE: out_load = 1'b1;
      default: ;
    endcase
  end

  assign tbl_wdata = wlevel_r ? vmin(tbl_rd_a_r, tbl_rd_b_r) : elem_rd_r;

  // ---------------------------------------------------------------------------
  // Element store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (elem_we) elem_mem[elem_waddr] <= elem_wdata;
    elem_rd_r <= elem_mem[cnt_r[IDX_W-1:0]];
  end

  // Level table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wpend_r) tbl_mem[waddr_r] <= tbl_wdata;
    tbl_rd_a_r <= tbl_mem[tbl_ra];
    tbl_rd_b_r <= tbl_mem[tbl_rb];
  end

  // ---------------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      cnt_r     <= '0;
      lvl_r     <= '0;
      wpend_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      lvl_r   <= lvl_nxt;
      wpend_r <= wpend_nxt;
      if (out_load) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wlevel_r <= wlevel_nxt;
    waddr_r  <= waddr_nxt;
    if (out_load) begin
      out_min_r <= out_min_nxt;
      out_st_r  <= out_st_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DW'(out_min_r);
  assign out_tuser  = out_st_r;

  // ---------------------------------------------------------------------------
  // Register port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= LEN_W'(LEN_RESET);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_LENGTH) begin
      length_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_LENGTH) ? CFG_DW'(length_r) : '0;

  // ---------------------------------------------------------------------------
  // Assertions
  ap_query_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && f_func == FN_QUERY && !q_bad) |=> state_r == ST_QUERY)
    else $error("good query did not enter the read-response state");

  ap_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !wpend_r)
    else $error("table write still pending while idle");

  ap_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QUERY || state_r == ST_DONE) |-> !out_vld_r)
    else $error("output register busy when a result lands");

endmodule
